@@ hdl/assert_macros.svh @@
// assertion macros shared by the packer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge outside reset
`define QSTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define QSTP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define QSTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/qstp_pkg.sv @@
// shared constants and types of the smallest-three quaternion packer
package qstp_pkg;

  localparam int COMP_WIDTH  = 16;
  localparam int FIELD_BITS  = 10;
  localparam int FRAC_BITS   = 30;

  localparam int SQ_W        = 2 * COMP_WIDTH - 1;
  localparam int SUM_W       = SQ_W + 2;
  localparam int QUO_W       = FRAC_BITS + 1;
  localparam int NORM_W      = FRAC_BITS / 2 + 1;
  localparam int RAD_W       = 2 * NORM_W;
  localparam int REM_W       = NORM_W + 2;

  localparam int BOUND_W     = 15;
  localparam int LIMIT_W     = 16;
  localparam int NB_W        = BOUND_W + 1;
  localparam int NUM_W       = NB_W + FIELD_BITS;
  localparam int DEN_W       = BOUND_W + 1;
  localparam int WORD_W      = 32;
  localparam int IDX_W       = 2;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_COMPONENT_BOUND       = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_SMALL_MAGNITUDE_LIMIT = CFG_INDEX_W'(1);

  localparam logic [BOUND_W-1:0] BOUND_RESET = BOUND_W'(23170);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(3);

  localparam logic [NORM_W-1:0]     NORM_ONE  = {1'b1, {(NORM_W-1){1'b0}}};
  localparam logic [FIELD_BITS-1:0] FIELD_MAX = '1;

  localparam int IDENT_FIELD = 1 << (FIELD_BITS - 1);
  localparam logic [WORD_W-1:0] IDENT_WORD =
      (WORD_W'(3) << (WORD_W - IDX_W)) |
      (WORD_W'(IDENT_FIELD) << (2 * FIELD_BITS)) |
      (WORD_W'(IDENT_FIELD) << FIELD_BITS) |
      WORD_W'(IDENT_FIELD);

  // request as held in the queue between front and back
  typedef struct packed {
    logic [3:0][SQ_W-1:0] sq;
    logic [3:0]           neg;
    logic [SUM_W-1:0]     sum;
    logic                 degen;
  } qstp_item_t;

  // normalized magnitudes with signs
  typedef struct packed {
    logic [3:0][NORM_W-1:0] mag;
    logic [3:0]             neg;
    logic                   degen;
  } qstp_norm_t;

endpackage

@@ hdl/qstp_channels.sv @@
// request and result channel interfaces of the packer
interface qstp_quat_if import qstp_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] comp_x;
  logic signed [COMP_WIDTH-1:0] comp_y;
  logic signed [COMP_WIDTH-1:0] comp_z;
  logic signed [COMP_WIDTH-1:0] comp_w;

  modport source (output valid, comp_x, comp_y, comp_z, comp_w, input ready);
  modport sink (input valid, comp_x, comp_y, comp_z, comp_w, output ready);
endinterface

interface qstp_pack_if import qstp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] packed_word;
  logic              degenerate;

  modport source (output valid, packed_word, degenerate, input ready);
  modport sink (input valid, packed_word, degenerate, output ready);
endinterface

@@ hdl/qstp_front.sv @@
// front end: squares, sum of squares and small-magnitude classification
module qstp_front import qstp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [LIMIT_W-1:0] limit,
  qstp_quat_if.sink          quat,
  input  logic               push_ok,
  output logic               push,
  output qstp_item_t         item
);

  logic                           v1;
  logic                           v2;
  logic [3:0][SQ_W-1:0]           sq1;
  logic [3:0]                     neg1;
  logic                           advance;
  logic [3:0][COMP_WIDTH-1:0]     comp;
  logic [3:0][COMP_WIDTH-1:0]     mag;
  logic [3:0][2*COMP_WIDTH-1:0]   prod;
  logic [SUM_W-1:0]               sum_next;

  assign comp[0] = quat.comp_x;
  assign comp[1] = quat.comp_y;
  assign comp[2] = quat.comp_z;
  assign comp[3] = quat.comp_w;

  assign advance    = !v2 || push_ok;
  assign quat.ready = advance;
  assign push       = v2;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      // full-scale negative maps to its exact magnitude
      mag[i]  = comp[i][COMP_WIDTH-1] ? (~comp[i] + 1'b1) : comp[i];
      prod[i] = mag[i] * mag[i];
    end
    sum_next = SUM_W'(sq1[0]) + SUM_W'(sq1[1]) + SUM_W'(sq1[2]) + SUM_W'(sq1[3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (advance) begin
      v1 <= quat.valid;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < 4; i++) begin
        sq1[i]  <= prod[i][SQ_W-1:0];
        neg1[i] <= comp[i][COMP_WIDTH-1];
      end
      item.sq    <= sq1;
      item.neg   <= neg1;
      item.sum   <= sum_next;
      item.degen <= sum_next <= SUM_W'(limit);
    end
  end

endmodule

@@ hdl/qstp_fifo.sv @@
// two-entry queue between the front end and the normalizing back end
`include "assert_macros.svh"
module qstp_fifo import qstp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  qstp_item_t din,
  output logic       push_ok,
  input  logic       pop_req,
  output logic       valid,
  output qstp_item_t dout
);

  qstp_item_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                pop;
  logic                wr;

  assign valid   = count != '0;
  assign pop     = pop_req && valid;
  assign push_ok = (count != QCNT_W'(QUEUE_DEPTH)) || pop;
  assign wr      = push && push_ok;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= QCNT_W'(count + QCNT_W'(wr) - QCNT_W'(pop));
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= din;
    end
  end

  `QSTP_ASSERT(a_count_max, count <= QCNT_W'(QUEUE_DEPTH), "queue over its depth")
  `QSTP_ASSERT_NEXT(a_count_up, wr && !pop, count == QCNT_W'($past(count) + 1'b1), "count lost a push")
  `QSTP_ASSERT_NEXT(a_count_down, pop && !wr, count == QCNT_W'($past(count) - 1'b1), "count lost a pop")

endmodule

@@ hdl/qstp_norm.sv @@
// back end part one: restoring divide by the sum, then digit-by-digit square root
module qstp_norm import qstp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_valid,
  input  qstp_item_t din,
  output logic       out_valid,
  output qstp_norm_t dout
);

  localparam int DIV_STAGES  = QUO_W;
  localparam int SQRT_STAGES = NORM_W;
  localparam int ALL_STAGES  = DIV_STAGES + SQRT_STAGES;

  typedef struct packed {
    logic [3:0][SUM_W-1:0] r;
    logic [3:0][QUO_W-1:0] q;
    logic [SUM_W-1:0]      sum;
    logic [3:0]            neg;
    logic                  degen;
  } div_stage_t;

  typedef struct packed {
    logic [3:0][RAD_W-1:0]  rad;
    logic [3:0][REM_W-1:0]  rem;
    logic [3:0][NORM_W-1:0] root;
    logic [3:0]             neg;
    logic                   degen;
  } sqrt_stage_t;

  function automatic div_stage_t div_step(input div_stage_t d);
    div_stage_t       o;
    logic [SUM_W:0]   r2;
    logic             ge;
    o = d;
    for (int l = 0; l < 4; l++) begin
      r2 = {d.r[l], 1'b0};
      ge = r2 >= {1'b0, d.sum};
      o.r[l] = ge ? SUM_W'(r2 - {1'b0, d.sum}) : SUM_W'(r2);
      o.q[l] = {d.q[l][QUO_W-2:0], ge};
    end
    return o;
  endfunction

  function automatic sqrt_stage_t sqrt_step(input sqrt_stage_t d);
    sqrt_stage_t      o;
    logic [REM_W+1:0] rem2;
    logic [REM_W+1:0] trial;
    logic             ge;
    o = d;
    for (int l = 0; l < 4; l++) begin
      rem2  = {d.rem[l], d.rad[l][RAD_W-1 -: 2]};
      trial = (REM_W+2)'({d.root[l], 2'b01});
      ge    = rem2 >= trial;
      o.rem[l]  = ge ? REM_W'(rem2 - trial) : REM_W'(rem2);
      o.root[l] = {d.root[l][NORM_W-2:0], ge};
      o.rad[l]  = {d.rad[l][RAD_W-3:0], 2'b00};
    end
    return o;
  endfunction

  div_stage_t             dv [DIV_STAGES];
  div_stage_t             dn [DIV_STAGES];
  sqrt_stage_t            sv [SQRT_STAGES];
  sqrt_stage_t            sn [SQRT_STAGES];
  sqrt_stage_t            s_init;
  div_stage_t             d0;
  logic [3:0]             ge0;
  logic [ALL_STAGES-1:0]  vld;

  // first quotient bit covers a component that carries the whole sum
  always_comb begin
    d0       = '0;
    d0.sum   = din.sum;
    d0.neg   = din.neg;
    d0.degen = din.degen;
    for (int l = 0; l < 4; l++) begin
      ge0[l]   = SUM_W'(din.sq[l]) >= din.sum;
      d0.r[l]  = ge0[l] ? SUM_W'(din.sq[l]) - din.sum : SUM_W'(din.sq[l]);
      d0.q[l]  = QUO_W'(ge0[l]);
    end
  end

  always_comb begin
    s_init       = '0;
    s_init.neg   = dv[DIV_STAGES-1].neg;
    s_init.degen = dv[DIV_STAGES-1].degen;
    for (int l = 0; l < 4; l++) begin
      s_init.rad[l] = RAD_W'(dv[DIV_STAGES-1].q[l]);
    end
  end

  assign dn[0] = d0;
  assign sn[0] = sqrt_step(s_init);

  for (genvar s = 1; s < DIV_STAGES; s++) begin : g_div
    assign dn[s] = div_step(dv[s-1]);
  end

  for (genvar j = 1; j < SQRT_STAGES; j++) begin : g_sqrt
    assign sn[j] = sqrt_step(sv[j-1]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[ALL_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
        dv[s] <= dn[s];
      end
      for (int j = 0; j < SQRT_STAGES; j++) begin
        sv[j] <= sn[j];
      end
    end
  end

  assign out_valid  = vld[ALL_STAGES-1];
  assign dout.mag   = sv[SQRT_STAGES-1].root;
  assign dout.neg   = sv[SQRT_STAGES-1].neg;
  assign dout.degen = sv[SQRT_STAGES-1].degen;

endmodule

@@ hdl/qstp_pack.sv @@
// back end part two: largest pick, clamp, rounded quantize and word packing
`include "assert_macros.svh"
module qstp_pack import qstp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [BOUND_W-1:0] bound,
  input  logic               in_valid,
  input  qstp_norm_t         din,
  output logic               advance,
  qstp_pack_if.source        res
);

  localparam int F = FIELD_BITS;

  typedef struct packed {
    logic [2:0][NORM_W-1:0] mag;
    logic [2:0]             neg;
    logic [IDX_W-1:0]       best;
    logic                   degen;
  } sel_t;

  typedef struct packed {
    logic [2:0][NB_W-1:0] r;
    logic [2:0][F-1:0]    lo;
    logic [2:0][F-1:0]    q;
    logic [DEN_W-1:0]     den;
    logic [IDX_W-1:0]     best;
    logic                 degen;
  } quo_t;

  function automatic quo_t quo_step(input quo_t d);
    quo_t          o;
    logic [NB_W:0] r2;
    logic          ge;
    o = d;
    for (int k = 0; k < 3; k++) begin
      r2 = {d.r[k], d.lo[k][F-1]};
      ge = r2 >= {1'b0, d.den};
      o.r[k]  = ge ? NB_W'(r2 - {1'b0, d.den}) : NB_W'(r2);
      o.q[k]  = {d.q[k][F-2:0], ge};
      o.lo[k] = {d.lo[k][F-2:0], 1'b0};
    end
    return o;
  endfunction

  logic                      p0v;
  sel_t                      sel;
  sel_t                      sel_next;
  logic [F:0]                vq;
  quo_t                      qp [F+1];
  quo_t                      qn [F+1];
  quo_t                      q_init;
  logic [3:0][NORM_W-1:0]    m;
  logic [3:0]                sg;
  logic [IDX_W-1:0]          best;
  logic [NORM_W-1:0]         mb;
  logic                      flip;
  logic [2:0][NORM_W-1:0]    mc;
  logic [2:0][NB_W-1:0]      nb;
  logic [2:0][NUM_W-1:0]     num;
  logic [NB_W:0]             rr;
  logic                      up;
  logic [2:0][F-1:0]         fld;
  logic [WORD_W-1:0]         word_next;

  assign advance = !res.valid || res.ready;

  // pick the largest magnitude, lowest index on a tie
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      m[i]  = din.degen ? ((i == 3) ? NORM_ONE : '0) : din.mag[i];
      sg[i] = din.degen ? 1'b0 : din.neg[i];
    end
    best = '0;
    mb   = m[0];
    for (int i = 1; i < 4; i++) begin
      if (m[i] > mb) begin
        mb   = m[i];
        best = IDX_W'(i);
      end
    end
    flip = sg[best];
    for (int k = 0; k < 3; k++) begin
      sel_next.mag[k] = (IDX_W'(k) < best) ? m[k] : m[k+1];
      sel_next.neg[k] = ((IDX_W'(k) < best) ? sg[k] : sg[k+1]) ^ flip;
    end
    sel_next.best  = best;
    sel_next.degen = din.degen;
  end

  // clamp to the bound and scale numerator by the field maximum
  always_comb begin
    q_init = '0;
    for (int k = 0; k < 3; k++) begin
      mc[k]  = (sel.mag[k] > NORM_W'(bound)) ? NORM_W'(bound) : sel.mag[k];
      nb[k]  = sel.neg[k] ? NB_W'(bound) - NB_W'(mc[k]) : NB_W'(bound) + NB_W'(mc[k]);
      num[k] = {nb[k], F'(0)} - NUM_W'(nb[k]);
      q_init.r[k]  = num[k][NUM_W-1:F];
      q_init.lo[k] = num[k][F-1:0];
    end
    q_init.den   = {bound, 1'b0};
    q_init.best  = sel.best;
    q_init.degen = sel.degen;
  end

  assign qn[0] = q_init;
  for (genvar s = 1; s <= F; s++) begin : g_quo
    assign qn[s] = quo_step(qp[s-1]);
  end

  // round half to even on the final remainder
  always_comb begin
    word_next = '0;
    word_next[WORD_W-1 -: IDX_W] = qp[F].best;
    for (int k = 0; k < 3; k++) begin
      rr = {qp[F].r[k], 1'b0};
      up = (rr > {1'b0, qp[F].den}) || ((rr == {1'b0, qp[F].den}) && qp[F].q[k][0]);
      fld[k] = (up && (qp[F].q[k] != FIELD_MAX)) ? qp[F].q[k] + 1'b1 : qp[F].q[k];
      word_next[F*(2-k) +: F] = fld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p0v       <= 1'b0;
      vq        <= '0;
      res.valid <= 1'b0;
    end else if (advance) begin
      p0v       <= in_valid;
      vq        <= {vq[F-1:0], p0v};
      res.valid <= vq[F];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sel <= sel_next;
      for (int s = 0; s <= F; s++) begin
        qp[s] <= qn[s];
      end
      res.packed_word <= word_next;
      res.degenerate  <= qp[F].degen;
    end
  end

  `QSTP_ASSERT_IMPL(a_ident_word, res.valid && res.degenerate, res.packed_word == IDENT_WORD, "identity word wrong")

endmodule

@@ hdl/quaternion_smallest_three_packer_unit.sv @@
// top level of the smallest-three quaternion packer
//
//   channel  dir  payload                          request taken when
//   quat     in   comp_x comp_y comp_z comp_w      quat.valid && quat.ready
//   word     out  packed_word degenerate           word.valid && word.ready
//   cfg      in   cfg_index cfg_data               cfg_we
//
// one request per cycle sustained while results are taken; the back end holds
// the 31-step divide and 16-step square root pipelines
// and the 10-step quantizer divide
// synchronous reset, no clearing pass; the back end freezes as a whole while
// a result waits, the two-entry queue lets the front keep taking requests
module quaternion_smallest_three_packer_unit import qstp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  qstp_quat_if.sink              quat,
  qstp_pack_if.source            word
);

  logic [BOUND_W-1:0] bound;
  logic [BOUND_W-1:0] bound_eff;
  logic [LIMIT_W-1:0] limit;
  logic               push;
  logic               push_ok;
  qstp_item_t         front_item;
  logic               q_valid;
  qstp_item_t         q_item;
  logic               advance;
  logic               n_valid;
  qstp_norm_t         n_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      bound <= BOUND_RESET;
      limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COMPONENT_BOUND:       bound <= cfg_data[BOUND_W-1:0];
        REG_SMALL_MAGNITUDE_LIMIT: limit <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // a zero bound behaves as one
  assign bound_eff = (bound == '0) ? BOUND_W'(1) : bound;

  qstp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .limit   (limit),
    .quat    (quat),
    .push_ok (push_ok),
    .push    (push),
    .item    (front_item)
  );

  qstp_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .din     (front_item),
    .push_ok (push_ok),
    .pop_req (advance),
    .valid   (q_valid),
    .dout    (q_item)
  );

  qstp_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (q_valid),
    .din       (q_item),
    .out_valid (n_valid),
    .dout      (n_item)
  );

  qstp_pack u_pack (
    .clk      (clk),
    .rst      (rst),
    .bound    (bound_eff),
    .in_valid (n_valid),
    .din      (n_item),
    .advance  (advance),
    .res      (word)
  );

endmodule
